>>> rtl/mpci_pkg.sv
// ----------------------------------------------------------------------------
// Mathieson pad charge integral: shared package
// Fixed-point constants, CORDIC tables, coefficient sets and shared types.
// ----------------------------------------------------------------------------
package mpci_pkg;

	localparam int MAX_PADS_DEF = 256;

	// Operation codes of an item.
	typedef enum logic [1:0] {
		OP_2D   = 2'd0,
		OP_X    = 2'd1,
		OP_Y    = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [3:0] CHAMBER_RESET = 4'd1;
	localparam logic [3:0] STATION1_MAX  = 4'd2;

	// CORDIC datapath word, Q24.
	localparam int CW = 28;
	typedef logic signed [CW-1:0] cord_t;

	localparam cord_t ONE_Q24    = 28'sd16777216;
	localparam cord_t INV_KH_Q24 = 28'sd20258439;
	localparam logic [29:0] LN2_Q24 = 30'd11629080;

	// Offsets at or above this many LN2 give e^-w below one LSB.
	localparam logic [40:0] BIG_LIM = 41'd290727000;

	localparam int QBITS      = 5;
	localparam int EXP_STEPS  = 22;
	localparam int DIV_STEPS  = 25;
	localparam int ATAN_STEPS = 20;

	// Register stages of one bound mapping lane.
	localparam int BM_LAT = 3 + QBITS + EXP_STEPS + 2 + DIV_STEPS + 1 + ATAN_STEPS + 1;

	localparam int ANG_W  = 26;
	localparam int TERM_W = 28;

	localparam cord_t ATANH_TAB [0:20] = '{
		28'sd0, 28'sd9215828, 28'sd4285116, 28'sd2108178, 28'sd1049945,
		28'sd524459, 28'sd262165, 28'sd131075, 28'sd65536, 28'sd32768,
		28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16
	};

	localparam cord_t ATAN_TAB [0:19] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
		28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
		28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32
	};

	// Coefficient sets: entry 0 station 1, entry 1 stations 2 to 5.
	localparam logic [23:0] SK3X [0:1] = '{24'd11744051, 24'd11963833};
	localparam logic [23:0] SK3Y [0:1] = '{24'd12666798, 24'd12821148};
	localparam logic [26:0] C2X  [0:1] = '{27'd81570633, 27'd67828868};
	localparam logic [26:0] C2Y  [0:1] = '{27'd78119568, 27'd65135531};
	localparam logic [23:0] CX   [0:1] = '{24'd13735470, 24'd13541723};
	localparam logic [23:0] CY   [0:1] = '{24'd12971537, 24'd12855437};

	// Hyperbolic CORDIC shift for each step; shifts 4 and 13 are repeated.
	function automatic int hyp_shift(input int s);
		if (s <= 3) return s + 1;
		else if (s <= 13) return s;
		else return s - 1;
	endfunction

	// Item side information that travels alongside the lanes.
	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [7:0]  pad;
		logic        start;
		logic [16:0] weight;
	} side_t;

	// Item handed to the accumulator unit.
	typedef struct packed {
		logic                     valid;
		logic [7:0]               pad;
		logic                     start;
		logic signed [TERM_W-1:0] term;
	} acc_item_t;

endpackage

>>> rtl/mpci_hit_if.sv
// ----------------------------------------------------------------------------
// Mathieson pad charge integral: input channel
// Valid/ready channel that carries one pad item.
// ----------------------------------------------------------------------------
interface mpci_hit_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  pad_index;
	logic        start_sum;
	logic signed [23:0] x_low;
	logic signed [23:0] x_high;
	logic signed [23:0] y_low;
	logic signed [23:0] y_high;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic [16:0] weight;

	modport source (output valid, operation, pad_index, start_sum, x_low, x_high,
		y_low, y_high, center_x, center_y, weight, input ready);
	modport sink (input valid, operation, pad_index, start_sum, x_low, x_high,
		y_low, y_high, center_x, center_y, weight, output ready);
endinterface

>>> rtl/mpci_charge_if.sv
// ----------------------------------------------------------------------------
// Mathieson pad charge integral: result channel
// Valid/ready channel that carries one updated pad accumulator.
// ----------------------------------------------------------------------------
interface mpci_charge_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pad_out;
	logic signed [31:0] accumulated_charge;
	logic        saturated;

	modport source (output valid, pad_out, accumulated_charge, saturated, input ready);
	modport sink (input valid, pad_out, accumulated_charge, saturated, output ready);
endinterface

>>> rtl/mpci_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpci_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mpci_bound_map.sv
// ----------------------------------------------------------------------------
// Bound mapping lane
// Pipelined atan(sqrtK3 * tanh(K2/pitch * (bound - centre))) in Q24.
// ----------------------------------------------------------------------------
module mpci_bound_map (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [23:0]         bound,
	input  logic signed [23:0]         centre,
	input  logic [26:0]                c2,
	input  logic [23:0]                sk3,
	output logic signed [mpci_pkg::ANG_W-1:0] angle
);

	localparam int QB = mpci_pkg::QBITS;
	localparam int NE = mpci_pkg::EXP_STEPS;
	localparam int ND = mpci_pkg::DIV_STEPS;
	localparam int NA = mpci_pkg::ATAN_STEPS;

	// Offset and magnitude.
	logic signed [24:0] diff;
	logic               neg_s1;
	logic [24:0]        mag_s1;

	assign diff = 25'(bound) - 25'(centre);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= diff[24];
			mag_s1 <= diff[24] ? 25'(-diff) : 25'(diff);
		end
	end

	// Scale by K2/pitch.
	logic [51:0] wprod;
	logic        neg_s2;
	logic [40:0] w_s2;

	assign wprod = 52'(mag_s1) * 52'(c2);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			w_s2   <= wprod[51:11];
		end
	end

	// Large offsets saturate tanh; only smaller ones need the remainder.
	logic        neg_s3;
	logic        big_s3;
	logic [29:0] r_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			big_s3 <= (w_s2 >= mpci_pkg::BIG_LIM);
			r_s3   <= (w_s2 >= mpci_pkg::BIG_LIM) ? '0 : w_s2[29:0];
		end
	end

	// Quotient and remainder by LN2, one quotient bit per stage.
	logic [29:0]   rq_q   [0:QB-1];
	logic [QB-1:0] qq_q   [0:QB-1];
	logic          qbig_q [0:QB-1];
	logic          qneg_q [0:QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_quo
		logic [29:0]   r_in;
		logic [QB-1:0] q_in;
		logic          big_in;
		logic          neg_in;
		logic [29:0]   lim;
		logic          take;

		if (k == 0) begin : g_first
			assign r_in   = r_s3;
			assign q_in   = '0;
			assign big_in = big_s3;
			assign neg_in = neg_s3;
		end else begin : g_next
			assign r_in   = rq_q[k-1];
			assign q_in   = qq_q[k-1];
			assign big_in = qbig_q[k-1];
			assign neg_in = qneg_q[k-1];
		end

		assign lim  = mpci_pkg::LN2_Q24 << (QB - 1 - k);
		assign take = (r_in >= lim);

		always_ff @(posedge clk) begin
			if (en) begin
				rq_q[k]   <= take ? (r_in - lim) : r_in;
				qq_q[k]   <= {q_in[QB-2:0], take};
				qbig_q[k] <= big_in;
				qneg_q[k] <= neg_in;
			end
		end
	end

	// Hyperbolic rotation gives cosh(r) and sinh(r); x - y is e^-r.
	mpci_pkg::cord_t ex_q [0:NE-1];
	mpci_pkg::cord_t ey_q [0:NE-1];
	mpci_pkg::cord_t ez_q [0:NE-1];
	logic [QB-1:0]   eq_q   [0:NE-1];
	logic            ebig_q [0:NE-1];
	logic            eneg_q [0:NE-1];

	for (genvar s = 0; s < NE; s++) begin : g_exp
		localparam int SH = mpci_pkg::hyp_shift(s);
		mpci_pkg::cord_t x_in;
		mpci_pkg::cord_t y_in;
		mpci_pkg::cord_t z_in;
		logic [QB-1:0]   q_in;
		logic            big_in;
		logic            neg_in;
		mpci_pkg::cord_t xs;
		mpci_pkg::cord_t ys;

		if (s == 0) begin : g_first
			assign x_in   = mpci_pkg::INV_KH_Q24;
			assign y_in   = '0;
			assign z_in   = mpci_pkg::cord_t'(rq_q[QB-1]);
			assign q_in   = qq_q[QB-1];
			assign big_in = qbig_q[QB-1];
			assign neg_in = qneg_q[QB-1];
		end else begin : g_next
			assign x_in   = ex_q[s-1];
			assign y_in   = ey_q[s-1];
			assign z_in   = ez_q[s-1];
			assign q_in   = eq_q[s-1];
			assign big_in = ebig_q[s-1];
			assign neg_in = eneg_q[s-1];
		end

		assign xs = x_in >>> SH;
		assign ys = y_in >>> SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_in[mpci_pkg::CW-1]) begin
					ex_q[s] <= x_in + ys;
					ey_q[s] <= y_in + xs;
					ez_q[s] <= z_in - mpci_pkg::ATANH_TAB[SH];
				end else begin
					ex_q[s] <= x_in - ys;
					ey_q[s] <= y_in - xs;
					ez_q[s] <= z_in + mpci_pkg::ATANH_TAB[SH];
				end
				eq_q[s]   <= q_in;
				ebig_q[s] <= big_in;
				eneg_q[s] <= neg_in;
			end
		end
	end

	// Clamp e^-r and scale by 2^-q.
	mpci_pkg::cord_t em;
	logic [24:0]     em_cl;
	logic [24:0]     ef_s4;
	logic            neg_s4;

	assign em = ex_q[NE-1] - ey_q[NE-1];

	always_comb begin
		if (em[mpci_pkg::CW-1]) begin
			em_cl = '0;
		end else if (em > mpci_pkg::ONE_Q24) begin
			em_cl = 25'(mpci_pkg::ONE_Q24);
		end else begin
			em_cl = em[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ef_s4  <= ebig_q[NE-1] ? '0 : (em_cl >> eq_q[NE-1]);
			neg_s4 <= eneg_q[NE-1];
		end
	end

	// Numerator and denominator of tanh.
	logic [24:0] num_s5;
	logic [25:0] den_s5;
	logic        neg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= 25'(mpci_pkg::ONE_Q24) - ef_s4;
			den_s5 <= 26'(mpci_pkg::ONE_Q24) + 26'(ef_s4);
			neg_s5 <= neg_s4;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	logic [26:0] rem_q  [0:ND-1];
	logic [ND-1:0] th_q [0:ND-1];
	logic [25:0] dden_q [0:ND-1];
	logic        dneg_q [0:ND-1];

	for (genvar j = 0; j < ND; j++) begin : g_div
		logic [26:0]   r_in;
		logic [26:0]   r_sh;
		logic [ND-1:0] t_in;
		logic [25:0]   d_in;
		logic          neg_in;
		logic          take;

		if (j == 0) begin : g_first
			assign r_in   = 27'(num_s5);
			assign r_sh   = r_in;
			assign t_in   = '0;
			assign d_in   = den_s5;
			assign neg_in = neg_s5;
		end else begin : g_next
			assign r_in   = rem_q[j-1];
			assign r_sh   = {r_in[25:0], 1'b0};
			assign t_in   = th_q[j-1];
			assign d_in   = dden_q[j-1];
			assign neg_in = dneg_q[j-1];
		end

		assign take = (r_sh >= 27'(d_in));

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= take ? (r_sh - 27'(d_in)) : r_sh;
				th_q[j]   <= {t_in[ND-2:0], take};
				dden_q[j] <= d_in;
				dneg_q[j] <= neg_in;
			end
		end
	end

	// Scale tanh by sqrtK3.
	logic [48:0] uprod;
	logic [24:0] u_s6;
	logic        neg_s6;

	assign uprod = 49'(sk3) * 49'(th_q[ND-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s6   <= uprod[48:24];
			neg_s6 <= dneg_q[ND-1];
		end
	end

	// Circular vectoring gives atan(u) in z.
	mpci_pkg::cord_t ax_q [0:NA-1];
	mpci_pkg::cord_t ay_q [0:NA-1];
	mpci_pkg::cord_t az_q [0:NA-1];
	logic            aneg_q [0:NA-1];

	for (genvar i = 0; i < NA; i++) begin : g_atan
		mpci_pkg::cord_t x_in;
		mpci_pkg::cord_t y_in;
		mpci_pkg::cord_t z_in;
		logic            neg_in;
		mpci_pkg::cord_t xs;
		mpci_pkg::cord_t ys;

		if (i == 0) begin : g_first
			assign x_in   = mpci_pkg::ONE_Q24;
			assign y_in   = mpci_pkg::cord_t'(u_s6);
			assign z_in   = '0;
			assign neg_in = neg_s6;
		end else begin : g_next
			assign x_in   = ax_q[i-1];
			assign y_in   = ay_q[i-1];
			assign z_in   = az_q[i-1];
			assign neg_in = aneg_q[i-1];
		end

		assign xs = x_in >>> i;
		assign ys = y_in >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[mpci_pkg::CW-1]) begin
					ax_q[i] <= x_in + ys;
					ay_q[i] <= y_in - xs;
					az_q[i] <= z_in + mpci_pkg::ATAN_TAB[i];
				end else begin
					ax_q[i] <= x_in - ys;
					ay_q[i] <= y_in + xs;
					az_q[i] <= z_in - mpci_pkg::ATAN_TAB[i];
				end
				aneg_q[i] <= neg_in;
			end
		end
	end

	// Restore the sign of the offset.
	mpci_pkg::cord_t zneg;

	assign zneg = -az_q[NA-1];

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= aneg_q[NA-1] ? zneg[mpci_pkg::ANG_W-1:0] : az_q[NA-1][mpci_pkg::ANG_W-1:0];
		end
	end

endmodule

>>> rtl/mpci_accum.sv
// ----------------------------------------------------------------------------
// Pad accumulator unit
// Read-modify-write of the per-pad sums in RAM, saturation, result register.
// ----------------------------------------------------------------------------
module mpci_accum #(
	parameter int MAX_PADS = mpci_pkg::MAX_PADS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  mpci_pkg::acc_item_t  item,
	output logic                 busy,
	output logic                 out_valid,
	output logic [7:0]           out_pad,
	output logic signed [31:0]   out_charge,
	output logic                 out_sat
);

	localparam int AW = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;

	mpci_pkg::acc_item_t item_s1;
	logic [31:0]         pad_in_w;
	logic [31:0]         pad_s1_w;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       addr_s1;
	logic                in_range_s1;
	logic [31:0]         rdata;

	logic                clearing_q;
	logic [AW-1:0]       clr_addr_q;

	logic                lw_valid_q;
	logic [AW-1:0]       lw_addr_q;
	logic signed [31:0]  lw_data_q;

	logic signed [31:0]  old;
	logic signed [32:0]  sum;
	logic signed [31:0]  acc;
	logic                sat;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [31:0]         wdata;

	assign pad_in_w    = 32'(item.pad);
	assign pad_s1_w    = 32'(item_s1.pad);
	assign raddr       = pad_in_w[AW-1:0];
	assign addr_s1     = pad_s1_w[AW-1:0];
	assign in_range_s1 = (pad_s1_w < 32'(MAX_PADS));
	assign busy        = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= item;
		end
	end

	// The write of the item just ahead lands in the same cycle as this read,
	// so its value is taken from the bypass register instead.
	always_comb begin
		if (item_s1.start) begin
			old = '0;
		end else if (lw_valid_q && (lw_addr_q == addr_s1)) begin
			old = lw_data_q;
		end else begin
			old = $signed(rdata);
		end
		sum = 33'(old) + 33'(item_s1.term);
		sat = 1'b0;
		if (sum > 33'sh0_7fff_ffff) begin
			acc = 32'sh7fff_ffff;
			sat = 1'b1;
		end else if (sum < -33'sh0_8000_0000) begin
			acc = 32'sh8000_0000;
			sat = 1'b1;
		end else begin
			acc = sum[31:0];
		end
	end

	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = en && item_s1.valid && in_range_s1;
			waddr = addr_s1;
			wdata = acc;
		end
	end

	mpci_ram #(
		.WIDTH (32),
		.DEPTH (MAX_PADS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(MAX_PADS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (en) begin
			lw_valid_q <= item_s1.valid && in_range_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pad    <= item_s1.pad;
			out_charge <= in_range_s1 ? acc : '0;
			out_sat    <= in_range_s1 && sat;
		end
	end

endmodule

>>> rtl/mathieson_pad_charge_integral.sv
// ----------------------------------------------------------------------------
// Mathieson pad charge integral
// Four bound mapping lanes, integral and weighting stages, pad accumulator.
// ----------------------------------------------------------------------------
// Channel   Role    Carries
// hit       sink    pad bounds, centre, weight, pad index, operation, start
// charge    source  pad index, saturated accumulator value, clip flag
// cfg       write   chamber number
//
// One item is accepted every cycle unless the output stalls or the clearing
// pass runs; an item's result passes through the lanes, the integral and
// weighting stages and the accumulator to the output register. After reset
// a pass clears the accumulator RAM, one entry per cycle, with the input
// held off. A stalled output freezes every stage, and accumulator reads
// bypass the write of the item just ahead.
// ----------------------------------------------------------------------------
module mathieson_pad_charge_integral #(
	parameter int MAX_PADS = mpci_pkg::MAX_PADS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mpci_hit_if.sink      hit,
	mpci_charge_if.source charge,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_wdata
);

	localparam int LAT = mpci_pkg::BM_LAT;

	logic        en;
	logic        busy;
	logic        set;
	logic [3:0]  chamber_q;

	assign en        = !charge.valid || charge.ready;
	assign hit.ready = en && !busy;
	assign set       = (chamber_q > mpci_pkg::STATION1_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chamber_q <= mpci_pkg::CHAMBER_RESET;
		end else if (cfg_we) begin
			chamber_q <= cfg_wdata;
		end
	end

	// Side information follows the lanes.
	mpci_pkg::side_t sb_q [0:LAT-1];
	logic [LAT-1:0]  sb_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				sb_q[k] <= '0;
			end
		end else if (en) begin
			sb_q[0].valid  <= hit.valid && hit.ready;
			sb_q[0].op     <= mpci_pkg::op_t'(hit.operation);
			sb_q[0].pad    <= hit.pad_index;
			sb_q[0].start  <= hit.start_sum;
			sb_q[0].weight <= hit.weight;
			for (int k = 1; k < LAT; k++) begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < LAT; k++) begin
			sb_valid[k] = sb_q[k].valid;
		end
	end

	logic signed [mpci_pkg::ANG_W-1:0] ax_lo, ax_hi, ay_lo, ay_hi;

	mpci_bound_map u_xlo (
		.clk (clk), .en (en), .bound (hit.x_low), .centre (hit.center_x),
		.c2 (mpci_pkg::C2X[set]), .sk3 (mpci_pkg::SK3X[set]), .angle (ax_lo)
	);
	mpci_bound_map u_xhi (
		.clk (clk), .en (en), .bound (hit.x_high), .centre (hit.center_x),
		.c2 (mpci_pkg::C2X[set]), .sk3 (mpci_pkg::SK3X[set]), .angle (ax_hi)
	);
	mpci_bound_map u_ylo (
		.clk (clk), .en (en), .bound (hit.y_low), .centre (hit.center_y),
		.c2 (mpci_pkg::C2Y[set]), .sk3 (mpci_pkg::SK3Y[set]), .angle (ay_lo)
	);
	mpci_bound_map u_yhi (
		.clk (clk), .en (en), .bound (hit.y_high), .centre (hit.center_y),
		.c2 (mpci_pkg::C2Y[set]), .sk3 (mpci_pkg::SK3Y[set]), .angle (ay_hi)
	);

	// Angle differences.
	mpci_pkg::side_t    side_s1, side_s2, side_s3, side_s4;
	logic signed [26:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else if (en) begin
			side_s1 <= sb_q[LAT-1];
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 27'(ax_hi) - 27'(ax_lo);
			dy_s1 <= 27'(ay_hi) - 27'(ay_lo);
		end
	end

	// One-dimensional integrals.
	logic signed [51:0] px, py;
	logic signed [26:0] ix_s2, iy_s2;

	assign px = 52'($signed({1'b0, mpci_pkg::CX[set]})) * 52'(dx_s1);
	assign py = 52'($signed({1'b0, mpci_pkg::CY[set]})) * 52'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s2 <= px[50:24];
			iy_s2 <= py[50:24];
		end
	end

	// Select by operation; the 2D case is the product of both axes.
	logic signed [53:0] pxy;
	logic signed [26:0] val;
	logic signed [26:0] val_s3;

	assign pxy = 54'(ix_s2) * 54'(iy_s2);

	always_comb begin
		case (side_s2.op)
			mpci_pkg::OP_2D: val = pxy[50:24];
			mpci_pkg::OP_X:  val = ix_s2;
			mpci_pkg::OP_Y:  val = iy_s2;
			default:         val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3 <= val;
		end
	end

	// Weighting.
	logic signed [44:0] pw;
	logic signed [mpci_pkg::TERM_W-1:0] term_s4;

	assign pw = 45'(val_s3) * 45'($signed({1'b0, side_s3.weight}));

	always_ff @(posedge clk) begin
		if (en) begin
			term_s4 <= pw[43:16];
		end
	end

	mpci_pkg::acc_item_t acc_item;

	assign acc_item.valid = side_s4.valid;
	assign acc_item.pad   = side_s4.pad;
	assign acc_item.start = side_s4.start;
	assign acc_item.term  = term_s4;

	mpci_accum #(
		.MAX_PADS (MAX_PADS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item       (acc_item),
		.busy       (busy),
		.out_valid  (charge.valid),
		.out_pad    (charge.pad_out),
		.out_charge (charge.accumulated_charge),
		.out_sat    (charge.saturated)
	);

`ifndef SYNTHESIS
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (sb_valid == '0))
		else $error("item in the lanes during the clearing pass");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(charge.valid && charge.saturated) |->
		(charge.accumulated_charge == 32'sh7fff_ffff ||
		 charge.accumulated_charge == 32'sh8000_0000))
		else $error("clip flag without a limit value");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(charge.valid && (32'(charge.pad_out) >= 32'(MAX_PADS))) |->
		(charge.accumulated_charge == '0 && !charge.saturated))
		else $error("nonzero result for a pad beyond the accumulator range");
`endif

endmodule
